/* src/bsu_pkg.sv */
// Shared types and constants of the breakpoint and step unit.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none

package bsu_pkg;

    localparam int ADDR_W = 16;
    localparam int OP_W   = 8;
    localparam int CMD_W  = 3;

    localparam int NUM_BREAKPOINTS_DEF = 8;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_CHECK  = 3'd0;
    localparam logic [CMD_W-1:0] CMD_ADD    = 3'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 3'd2;
    localparam logic [CMD_W-1:0] CMD_CLEAR  = 3'd3;
    localparam logic [CMD_W-1:0] CMD_STEP   = 3'd4;
    localparam logic [CMD_W-1:0] CMD_STEPOUT = 3'd5;

    // Configuration port
    localparam int CFG_ADDR_W = 2;
    localparam int CFG_DATA_W = 32;
    localparam logic [CFG_ADDR_W-1:0] REG_RETURN_OPCODE = 2'd0;
    localparam logic [OP_W-1:0] RETURN_OPCODE_RESET = 8'h60;

    // Per-slot update request
    typedef struct packed {
        logic set;  // load address, mark valid
        logic clr;  // drop valid mark
    } t_slot_ctl;

endpackage

`default_nettype wire

/* src/bsu_slot.sv */
// One breakpoint table slot: address register, valid bit and address comparator.
// Depends on bsu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bsu_slot (
    input  wire                       i_clk,
    input  wire                       i_rst_n,
    input  bsu_pkg::t_slot_ctl        i_ctl,
    input  wire [bsu_pkg::ADDR_W-1:0] i_address,
    output logic                      o_valid,
    output logic                      o_match
);
    import bsu_pkg::*;

    logic              r_valid;
    logic [ADDR_W-1:0] r_address;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_ctl.set) begin
            r_valid <= 1'b1;
        end else if (i_ctl.clr) begin
            r_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.set) begin
            r_address <= i_address;
        end
    end

    assign o_valid = r_valid;
    assign o_match = r_valid && (r_address == i_address);

endmodule

`default_nettype wire

/* src/bsu_cfg.sv */
// APB-style register port holding the step-out return opcode.
// Depends on bsu_pkg.
`timescale 1ns / 1ps
`default_nettype none

module bsu_cfg (
    input  wire                           i_clk,
    input  wire                           i_rst_n,
    input  wire                           psel,
    input  wire                           penable,
    input  wire                           pwrite,
    input  wire [bsu_pkg::CFG_ADDR_W-1:0] paddr,
    input  wire [bsu_pkg::CFG_DATA_W-1:0] pwdata,
    output logic [bsu_pkg::CFG_DATA_W-1:0] prdata,
    output logic                          pready,
    output logic [bsu_pkg::OP_W-1:0]      o_return_opcode
);
    import bsu_pkg::*;

    logic [OP_W-1:0] r_return_opcode;
    logic            wr_en;

    assign pready = 1'b1;
    assign wr_en  = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_return_opcode <= RETURN_OPCODE_RESET;
        end else if (wr_en && (paddr == REG_RETURN_OPCODE)) begin
            r_return_opcode <= pwdata[OP_W-1:0];
        end
    end

    always_comb begin
        if (paddr == REG_RETURN_OPCODE) begin
            prdata = {{(CFG_DATA_W-OP_W){1'b0}}, r_return_opcode};
        end else begin
            prdata = '0;
        end
    end

    assign o_return_opcode = r_return_opcode;

endmodule

`default_nettype wire

/* src/breakpoint_and_step_unit.sv */
// Breakpoint and single-step unit: top level with request register, table and result register.
// Depends on bsu_pkg, bsu_slot and bsu_cfg.
// A request goes through the request register and then the result register to its strobe.
// Throughput: one request per cycle; busy never rises, the table is compared in parallel.
// The receiver cannot stall: each result is shown for exactly one cycle on o_valid.
// Synchronous reset clears all valid bits, the step flags and sets return opcode to 0x60.
`timescale 1ns / 1ps
`default_nettype none

module breakpoint_and_step_unit #(
    parameter int NUM_BREAKPOINTS = bsu_pkg::NUM_BREAKPOINTS_DEF
) (
    input  wire                            i_clk,
    input  wire                            i_rst_n,
    // request channel
    input  wire                            start,
    output logic                           busy,
    input  wire [bsu_pkg::CMD_W-1:0]       i_command,
    input  wire [bsu_pkg::ADDR_W-1:0]      i_address,
    input  wire [bsu_pkg::OP_W-1:0]        i_opcode,
    // result channel
    output logic                           o_valid,
    output logic                           o_halt,
    output logic                           o_breakpoint_hit,
    output logic                           o_op_ok,
    output logic                           o_any_set,
    // configuration port
    input  wire                            psel,
    input  wire                            penable,
    input  wire                            pwrite,
    input  wire [bsu_pkg::CFG_ADDR_W-1:0]  paddr,
    input  wire [bsu_pkg::CFG_DATA_W-1:0]  pwdata,
    output logic [bsu_pkg::CFG_DATA_W-1:0] prdata,
    output logic                           pready
);
    import bsu_pkg::*;

    // Request register
    logic              r_in_valid;
    logic [CMD_W-1:0]  r_cmd;
    logic [ADDR_W-1:0] r_addr;
    logic [OP_W-1:0]   r_op;

    // Step control flags
    logic r_single_step, n_single_step;
    logic r_stepping_out, n_stepping_out;

    // Result register
    logic r_out_valid;
    logic r_halt, n_halt;
    logic r_hit, n_hit;
    logic r_ok, n_ok;
    logic r_any, n_any;

    logic [OP_W-1:0]            return_opcode;
    logic [NUM_BREAKPOINTS-1:0] valid_vec;
    logic [NUM_BREAKPOINTS-1:0] match_vec;
    logic [NUM_BREAKPOINTS-1:0] free_vec;
    logic [NUM_BREAKPOINTS-1:0] add_sel;
    logic [NUM_BREAKPOINTS-1:0] rem_sel;
    logic [NUM_BREAKPOINTS-1:0] n_valid_vec;
    t_slot_ctl                  slot_ctl [NUM_BREAKPOINTS];

    logic is_add, is_remove, is_clear;

    // The unit takes a request every cycle.
    assign busy = 1'b0;

    // Capture the request; no payload reset needed.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else begin
            r_in_valid <= start && !busy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (start && !busy) begin
            r_cmd  <= i_command;
            r_addr <= i_address;
            r_op   <= i_opcode;
        end
    end

    bsu_cfg u_cfg (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready),
        .o_return_opcode (return_opcode)
    );

    // Table of slots, all compared against the held address at once.
    for (genvar g = 0; g < NUM_BREAKPOINTS; g++) begin : g_slot
        bsu_slot u_slot (
            .i_clk     (i_clk),
            .i_rst_n   (i_rst_n),
            .i_ctl     (slot_ctl[g]),
            .i_address (r_addr),
            .o_valid   (valid_vec[g]),
            .o_match   (match_vec[g])
        );
    end

    assign is_add    = r_in_valid && (r_cmd == CMD_ADD);
    assign is_remove = r_in_valid && (r_cmd == CMD_REMOVE);
    assign is_clear  = r_in_valid && (r_cmd == CMD_CLEAR);

    // Isolate the lowest free slot and the lowest matching slot.
    assign free_vec = ~valid_vec;
    assign add_sel  = free_vec & (~free_vec + NUM_BREAKPOINTS'(1));
    assign rem_sel  = match_vec & (~match_vec + NUM_BREAKPOINTS'(1));

    always_comb begin
        for (int i = 0; i < NUM_BREAKPOINTS; i++) begin
            slot_ctl[i].set = is_add && add_sel[i];
            slot_ctl[i].clr = (is_remove && rem_sel[i]) || is_clear;
        end
    end

    // Table contents after this request, for the any-set flag.
    always_comb begin
        n_valid_vec = valid_vec;
        if (is_add) begin
            n_valid_vec = valid_vec | add_sel;
        end else if (is_remove) begin
            n_valid_vec = valid_vec & ~rem_sel;
        end else if (is_clear) begin
            n_valid_vec = '0;
        end
    end

    // Command decode: flags and result fields.
    always_comb begin
        n_single_step  = r_single_step;
        n_stepping_out = r_stepping_out;
        n_halt         = 1'b0;
        n_hit          = 1'b0;
        n_ok           = 1'b1;
        n_any          = |n_valid_vec;
        if (r_in_valid) begin
            unique case (r_cmd)
                CMD_CHECK: begin
                    n_hit = |match_vec;
                    // In step-out mode only the return opcode releases the check.
                    if (!r_stepping_out || (r_op == return_opcode)) begin
                        n_stepping_out = 1'b0;
                        if (r_single_step || n_hit) begin
                            n_halt        = 1'b1;
                            n_single_step = 1'b0;
                        end
                    end
                end
                CMD_ADD: begin
                    n_ok = |free_vec;
                end
                CMD_REMOVE: begin
                    n_ok = |match_vec;
                end
                CMD_CLEAR: begin
                    n_ok = 1'b1;
                end
                CMD_STEP: begin
                    n_single_step = 1'b1;
                end
                CMD_STEPOUT: begin
                    n_stepping_out = 1'b1;
                end
                default: begin
                    // unused codes do nothing
                    n_ok = 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_single_step  <= 1'b0;
            r_stepping_out <= 1'b0;
            r_out_valid    <= 1'b0;
        end else begin
            r_single_step  <= n_single_step;
            r_stepping_out <= n_stepping_out;
            r_out_valid    <= r_in_valid;
        end
    end

    // Hold the result fields for their one-cycle strobe.
    always_ff @(posedge i_clk) begin
        if (r_in_valid) begin
            r_halt <= n_halt;
            r_hit  <= n_hit;
            r_ok   <= n_ok;
            r_any  <= n_any;
        end
    end

    assign o_valid          = r_out_valid;
    assign o_halt           = r_halt;
    assign o_breakpoint_hit = r_hit;
    assign o_op_ok          = r_ok;
    assign o_any_set        = r_any;

`ifndef SYNTHESIS
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_in_valid |=> o_valid)
        else $error("held request produced no result strobe");

    a_halt_on_check: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_halt) |-> ($past(r_cmd) == CMD_CHECK))
        else $error("halt raised for a command other than check");

    a_halt_clears_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && o_halt) |-> !r_single_step)
        else $error("single step still pending after a halt");

    a_fail_only_add_remove: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_op_ok) |->
        (($past(r_cmd) == CMD_ADD) || ($past(r_cmd) == CMD_REMOVE)))
        else $error("failure reported for a command that cannot fail");

    a_any_set_matches_table: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_any_set == (|valid_vec)))
        else $error("any-set flag disagrees with the table");
`endif

endmodule

`default_nettype wire
